[rtl/core/spq_pkg.sv]
// Shared types and constants for the stable priority queue.
package spq_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int OCC_W = 5;
    localparam int ID_W  = 16;
    localparam int PRI_W = 8;
    localparam int CMD_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_CLEAR  = 2'd2
    } t_spq_cmd;

endpackage

[rtl/core/spq_if.sv]
// Command and result channel interfaces of the stable priority queue.
interface spq_cmd_if
    import spq_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [ID_W-1:0]    item_id;
    logic [PRI_W-1:0]   item_priority;

    modport source (output valid, cmd, item_id, item_priority, input ready);
    modport sink   (input valid, cmd, item_id, item_priority, output ready);
endinterface

interface spq_res_if
    import spq_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               resp_valid;
    logic [ID_W-1:0]    resp_id;
    logic [PRI_W-1:0]   resp_priority;
    logic               head_valid;
    logic [ID_W-1:0]    head_id;
    logic [PRI_W-1:0]   head_priority;
    logic [OCC_W-1:0]   occupancy;
    logic               overflow;

    modport source (output valid, resp_valid, resp_id, resp_priority, head_valid, head_id,
                    head_priority, occupancy, overflow, input ready);
    modport sink   (input valid, resp_valid, resp_id, resp_priority, head_valid, head_id,
                    head_priority, occupancy, overflow, output ready);
endinterface

[rtl/core/stable_priority_queue.sv]
// Stable minimum priority queue over a sorted register array.
//
//   channel    dir  transfer when           payload
//   i_cmd_ch   in   valid & ready           cmd, item_id, item_priority
//   o_res_ch   out  valid & ready           resp_*, head_*, occupancy, overflow
//
// One command per cycle; its result appears in the result register the next cycle.
// The rate rests on a combinational compare-and-shift across all DEPTH slots.
// Synchronous active-low reset empties the queue and drops any pending result.
// The command side stalls only while a finished result waits and o_res_ch.ready is low.
module stable_priority_queue
    import spq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    spq_cmd_if.sink    i_cmd_ch,
    spq_res_if.source  o_res_ch
);

    logic [PRI_W-1:0] r_pri [DEPTH];
    logic [ID_W-1:0]  r_id  [DEPTH];
    logic [CNT_W-1:0] r_count;

    logic [PRI_W-1:0] n_pri [DEPTH];
    logic [ID_W-1:0]  n_id  [DEPTH];
    logic [CNT_W-1:0] n_count;

    logic [DEPTH-1:0] le;
    logic             n_resp_valid;
    logic [ID_W-1:0]  n_resp_id;
    logic [PRI_W-1:0] n_resp_pri;
    logic             n_ovf;

    logic             r_out_valid;
    logic             r_resp_valid;
    logic [ID_W-1:0]  r_resp_id;
    logic [PRI_W-1:0] r_resp_pri;
    logic             r_head_valid;
    logic [ID_W-1:0]  r_head_id;
    logic [PRI_W-1:0] r_head_pri;
    logic [OCC_W-1:0] r_occ;
    logic             r_ovf;

    logic             accept;

    assign i_cmd_ch.ready = !r_out_valid || o_res_ch.ready;
    assign accept         = i_cmd_ch.valid && i_cmd_ch.ready;

    // held slots at or below the new priority; thermometer since slots are sorted
    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            le[k] = (r_count > CNT_W'(k)) && (r_pri[k] <= i_cmd_ch.item_priority);
        end
    end

    always_comb begin
        n_pri        = r_pri;
        n_id         = r_id;
        n_count      = r_count;
        n_resp_valid = 1'b0;
        n_resp_id    = '0;
        n_resp_pri   = '0;
        n_ovf        = 1'b0;
        case (t_spq_cmd'(i_cmd_ch.cmd))
            CMD_INSERT: begin
                if (r_count == CNT_W'(DEPTH)) begin
                    n_ovf = 1'b1;
                end else begin
                    for (int k = 0; k < DEPTH; k++) begin
                        if (le[k]) begin
                            n_pri[k] = r_pri[k];
                            n_id[k]  = r_id[k];
                        end else if (k == 0 || le[(k == 0) ? 0 : k-1]) begin
                            n_pri[k] = i_cmd_ch.item_priority;
                            n_id[k]  = i_cmd_ch.item_id;
                        end else begin
                            n_pri[k] = r_pri[(k == 0) ? 0 : k-1];
                            n_id[k]  = r_id[(k == 0) ? 0 : k-1];
                        end
                    end
                    n_count = r_count + CNT_W'(1);
                end
            end
            CMD_REMOVE: begin
                if (r_count != '0) begin
                    n_resp_valid = 1'b1;
                    n_resp_id    = r_id[0];
                    n_resp_pri   = r_pri[0];
                    // advance every slot toward the head
                    for (int k = 0; k < DEPTH - 1; k++) begin
                        n_pri[k] = r_pri[k+1];
                        n_id[k]  = r_id[k+1];
                    end
                    n_count = r_count - CNT_W'(1);
                end
            end
            CMD_CLEAR: begin
                n_count = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pri <= n_pri;
            r_id  <= n_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count <= n_count;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (o_res_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload; head reads zero when the queue is empty
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_resp_valid <= n_resp_valid;
            r_resp_id    <= n_resp_id;
            r_resp_pri   <= n_resp_pri;
            r_head_valid <= (n_count != '0);
            r_head_id    <= (n_count != '0) ? n_id[0] : '0;
            r_head_pri   <= (n_count != '0) ? n_pri[0] : '0;
            r_occ        <= OCC_W'(n_count);
            r_ovf        <= n_ovf;
        end
    end

    assign o_res_ch.valid         = r_out_valid;
    assign o_res_ch.resp_valid    = r_resp_valid;
    assign o_res_ch.resp_id       = r_resp_id;
    assign o_res_ch.resp_priority = r_resp_pri;
    assign o_res_ch.head_valid    = r_head_valid;
    assign o_res_ch.head_id       = r_head_id;
    assign o_res_ch.head_priority = r_head_pri;
    assign o_res_ch.occupancy     = r_occ;
    assign o_res_ch.overflow      = r_ovf;

endmodule

[rtl/core/spq_checker.sv]
// Port-level checks for the stable priority queue, bound to the top level.
module spq_checker
    import spq_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_res_valid,
    input logic             i_res_ready,
    input logic             i_resp_valid,
    input logic             i_head_valid,
    input logic [OCC_W-1:0] i_occupancy,
    input logic             i_overflow
);

    // a pending result holds until transferred
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result dropped while stalled");

    a_occ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> i_occupancy <= OCC_W'(DEPTH))
        else $error("occupancy above depth");

    a_head_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_head_valid == (i_occupancy != '0)))
        else $error("head valid disagrees with occupancy");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_overflow |-> i_occupancy == OCC_W'(DEPTH) && !i_resp_valid)
        else $error("overflow flagged on a queue that is not full");

endmodule

bind stable_priority_queue spq_checker u_spq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_res_valid  (o_res_ch.valid),
    .i_res_ready  (o_res_ch.ready),
    .i_resp_valid (o_res_ch.resp_valid),
    .i_head_valid (o_res_ch.head_valid),
    .i_occupancy  (o_res_ch.occupancy),
    .i_overflow   (o_res_ch.overflow)
);

[tb/spq_shadow_pkg.sv]
// Shadow copy of the priority queue and the store of results it predicts.
package spq_shadow_pkg;
    import spq_pkg::*;

    // Command code 3 has no meaning; the block must treat it as a no-op.
    localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [PRI_W-1:0] pri;
    } t_entry;

    typedef struct packed {
        logic             resp_valid;
        logic [ID_W-1:0]  resp_id;
        logic [PRI_W-1:0] resp_priority;
        logic             head_valid;
        logic [ID_W-1:0]  head_id;
        logic [PRI_W-1:0] head_priority;
        logic [OCC_W-1:0] occupancy;
        logic             overflow;
    } t_result;

    class spq_shadow;
        t_entry  held[$];
        t_result pending_results[$];
        int      errors;
        int      checked;
        int      n_cmds;
        int      n_served;
        int      n_empty_removes;
        int      n_dropped;
        int      n_clears;
        int      n_nops;
        int      peak;

        function void note_command(logic [CMD_W-1:0] op, logic [ID_W-1:0] id,
                                   logic [PRI_W-1:0] pri);
            t_result r;
            t_entry  e;
            int      pos;
            r     = '0;
            e.id  = id;
            e.pri = pri;
            pos   = 0;
            n_cmds++;
            case (op)
                CMD_INSERT: begin
                    if (held.size() >= DEPTH) begin
                        r.overflow = 1'b1;
                        n_dropped++;
                    end else begin
                        // go behind every held entry of equal priority
                        while (pos < held.size() && held[pos].pri <= pri)
                            pos++;
                        held.insert(pos, e);
                    end
                end
                CMD_REMOVE: begin
                    if (held.size() > 0) begin
                        r.resp_valid    = 1'b1;
                        r.resp_id       = held[0].id;
                        r.resp_priority = held[0].pri;
                        void'(held.pop_front());
                        n_served++;
                    end else begin
                        n_empty_removes++;
                    end
                end
                CMD_CLEAR: begin
                    held.delete();
                    n_clears++;
                end
                default: n_nops++;
            endcase
            if (held.size() > 0) begin
                r.head_valid    = 1'b1;
                r.head_id       = held[0].id;
                r.head_priority = held[0].pri;
            end
            r.occupancy = OCC_W'(held.size());
            if (held.size() > peak)
                peak = held.size();
            pending_results.push_back(r);
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        task report(string field, logic [31:0] want, logic [31:0] got);
            errors++;
            if (errors <= 40)
                $display("mismatch at result %0d: %s expected %0h got %0h",
                         checked, field, want, got);
        endtask

        task check_result(t_result got);
            t_result want;
            checked++;
            if (pending_results.size() == 0) begin
                report("unexpected result", 0, 0);
                return;
            end
            want = pending_results.pop_front();
            if (got.resp_valid !== want.resp_valid)
                report("resp_valid", want.resp_valid, got.resp_valid);
            if (got.resp_id !== want.resp_id)
                report("resp_id", want.resp_id, got.resp_id);
            if (got.resp_priority !== want.resp_priority)
                report("resp_priority", want.resp_priority, got.resp_priority);
            if (got.head_valid !== want.head_valid)
                report("head_valid", want.head_valid, got.head_valid);
            if (got.head_id !== want.head_id)
                report("head_id", want.head_id, got.head_id);
            if (got.head_priority !== want.head_priority)
                report("head_priority", want.head_priority, got.head_priority);
            if (got.occupancy !== want.occupancy)
                report("occupancy", want.occupancy, got.occupancy);
            if (got.overflow !== want.overflow)
                report("overflow", want.overflow, got.overflow);
        endtask
    endclass

endpackage

[tb/tb_top.sv]
// Self-checking bench for the stable priority queue: directed and random commands.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import spq_pkg::*;
    import spq_shadow_pkg::*;

    localparam int IDLE_LIMIT  = 2000;
    localparam int RANDOM_CMDS = 1575;
    localparam int CALM_FROM   = 1400;

    logic i_clk;
    logic i_rst_n;

    spq_cmd_if cmd_ch ();
    spq_res_if res_ch ();

    stable_priority_queue dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd_ch (cmd_ch),
        .o_res_ch (res_ch)
    );

    spq_shadow shadow = new();
    bit        calm;
    int        stall_left;
    int        idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Result side: check every transfer, stall ready in random bursts.
    initial begin
        t_result seen;
        res_ch.ready <= 1'b0;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_ch.valid && res_ch.ready) begin
                seen.resp_valid    = res_ch.resp_valid;
                seen.resp_id       = res_ch.resp_id;
                seen.resp_priority = res_ch.resp_priority;
                seen.head_valid    = res_ch.head_valid;
                seen.head_id       = res_ch.head_id;
                seen.head_priority = res_ch.head_priority;
                seen.occupancy     = res_ch.occupancy;
                seen.overflow      = res_ch.overflow;
                shadow.check_result(seen);
            end
            if (calm) begin
                stall_left = 0;
                res_ch.ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                res_ch.ready <= (stall_left == 0);
            end else if ($urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 19);
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("no transfer for %0d cycles", IDLE_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic send_cmd(logic [CMD_W-1:0] op, logic [ID_W-1:0] id,
                            logic [PRI_W-1:0] pri);
        if (!calm && $urandom_range(0, 5) == 0) begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        cmd_ch.valid         <= 1'b1;
        cmd_ch.cmd           <= op;
        cmd_ch.item_id       <= id;
        cmd_ch.item_priority <= pri;
        do @(posedge i_clk); while (!cmd_ch.ready);
        shadow.note_command(op, id, pri);
    endtask

    // Drop valid and hold until every predicted result has been delivered.
    task automatic hold_until_drained();
        cmd_ch.valid <= 1'b0;
        do @(posedge i_clk); while (shadow.pending() != 0);
    endtask

    task automatic run_directed();
        send_cmd(CMD_REMOVE, 16'h1234, 8'h55);
        send_cmd(CMD_NOP, 16'hBEEF, 8'hAA);
        send_cmd(CMD_INSERT, 16'hFFFF, 8'hFF);
        send_cmd(CMD_INSERT, 16'h0000, 8'h00);
        send_cmd(CMD_REMOVE, 16'h0000, 8'h00);
        send_cmd(CMD_CLEAR, 16'h5A5A, 8'h0F);
        // fill with repeated priorities so ties must keep arrival order
        for (int k = 0; k < DEPTH; k++)
            send_cmd(CMD_INSERT, {8'hA5, 8'(k)}, 8'((k * 7) % 4));
        send_cmd(CMD_INSERT, 16'hFFFF, 8'h00);
        send_cmd(CMD_NOP, 16'h0F0F, 8'hF0);
        send_cmd(CMD_REMOVE, 16'h0000, 8'h00);
        send_cmd(CMD_CLEAR, 16'h0000, 8'h00);
    endtask

    task automatic run_random();
        int               mode;
        int               roll;
        int               insert_pct;
        logic [CMD_W-1:0] op;
        logic [PRI_W-1:0] pri;
        mode = 0;
        for (int n = 0; n < RANDOM_CMDS; n++) begin
            if (n % 48 == 0)
                mode = $urandom_range(0, 3);
            if (n == RANDOM_CMDS / 2)
                hold_until_drained();
            calm = (n >= CALM_FROM);
            // fill-heavy, drain-heavy, balanced, and balanced with few distinct priorities
            case (mode)
                0:       insert_pct = 75;
                1:       insert_pct = 25;
                default: insert_pct = 48;
            endcase
            roll = $urandom_range(0, 99);
            if (roll < insert_pct)
                op = CMD_INSERT;
            else if (roll < 96)
                op = CMD_REMOVE;
            else if (roll < 98)
                op = CMD_CLEAR;
            else
                op = CMD_NOP;
            if (mode == 3)
                pri = 8'($urandom_range(0, 3));
            else if ($urandom_range(0, 7) == 0)
                pri = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            else
                pri = 8'($urandom_range(0, 255));
            send_cmd(op, 16'($urandom_range(0, 65535)), pri);
        end
    endtask

    initial begin
        i_rst_n              <= 1'b0;
        cmd_ch.valid         <= 1'b0;
        cmd_ch.cmd           <= CMD_INSERT;
        cmd_ch.item_id       <= '0;
        cmd_ch.item_priority <= '0;
        calm        = 1'b0;
        idle_cycles = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        hold_until_drained();
        run_random();
        hold_until_drained();
        repeat (8) @(posedge i_clk);

        $display("%0d commands: %0d entries served, %0d removes on empty, %0d inserts dropped",
                 shadow.n_cmds, shadow.n_served, shadow.n_empty_removes, shadow.n_dropped);
        $display("%0d clears, %0d unused codes, peak occupancy %0d, %0d mismatches",
                 shadow.n_clears, shadow.n_nops, shadow.peak, shadow.errors);
        if (shadow.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
